// ----- rtl/ptt_pkg.sv -----
// ptt_pkg: shared types and codes for the periodic timer table
// no dependencies
`timescale 1ns / 1ps
package ptt_pkg;

	localparam int KIND_BITS = 4;
	localparam int ID_BITS = 4;
	localparam int OWNER_W = 16;
	localparam int TIME_W = 32;
	localparam int TOTAL_BITS = 16;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_START = 4'd1;
	localparam logic [3:0] OP_STOP = 4'd2;
	localparam logic [3:0] OP_REMOVE = 4'd3;
	localparam logic [3:0] OP_BIND = 4'd4;
	localparam logic [3:0] OP_REM_OWNER = 4'd5;
	localparam logic [3:0] OP_START_ALL = 4'd6;
	localparam logic [3:0] OP_STOP_ALL = 4'd7;
	localparam logic [3:0] OP_REM_ALL = 4'd8;
	localparam logic [3:0] OP_TICK = 4'd9;
	localparam logic [3:0] OP_RESYNC = 4'd10;

	localparam logic [1:0] RES_ADDED = 2'd0;
	localparam logic [1:0] RES_FIRED = 2'd1;
	localparam logic [1:0] RES_DONE = 2'd2;
	localparam logic [1:0] RES_FULL = 2'd3;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [ID_BITS-1:0] timer_id;
		logic [OWNER_W-1:0] owner_tag;
		logic [TIME_W-1:0] period;
		logic [TOTAL_BITS-1:0] repeat_total;
		logic [TIME_W-1:0] now;
		logic paused;
	} cmd_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [ID_BITS-1:0] slot_id;
		logic last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture command word
		logic clr_idx; // index back to zero
		logic step;    // apply op on current slot, advance index
	} ptt_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic idx_last; // current slot is the final one
		logic fire;     // current slot fires on a tick step
		logic found;    // current slot is free (add search)
	} ptt_stat_t;

endpackage

// ----- rtl/ptt_ctrl.sv -----
// ptt_ctrl: command sequencer for the timer table
// depends on ptt_pkg
`timescale 1ns / 1ps
module ptt_ctrl import ptt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [KIND_BITS-1:0] kind,
	input  logic      paused,
	input  ptt_stat_t stat,
	output ptt_ctl_t  ctl,
	output logic      busy,
	output logic      strobe,
	output res_t      result
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [KIND_BITS-1:0] kind_q;
	logic [ID_BITS-1:0] idx_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ctl = '0;
		strobe = 1'b0;
		result = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.load = start;
				ctl.clr_idx = start;
			end
			ST_WALK: begin
				ctl.step = 1'b1;
				if (kind_q == OP_TICK && stat.fire) begin
					strobe = 1'b1;
					result.result_kind = RES_FIRED;
					result.slot_id = idx_q;
				end
			end
			ST_ADD: begin
				ctl.step = stat.found;
				if (stat.found) begin
					strobe = 1'b1;
					result.result_kind = RES_ADDED;
					result.slot_id = idx_q;
					result.last = 1'b1;
				end else if (stat.idx_last) begin
					strobe = 1'b1;
					result.result_kind = RES_FULL;
					result.last = 1'b1;
				end else begin
					ctl.step = 1'b1;
				end
			end
			ST_DONE: begin
				strobe = 1'b1;
				result.result_kind = RES_DONE;
				result.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= '0;
			idx_q <= '0;
		end else begin
			if (ctl.clr_idx) idx_q <= '0;
			else if (ctl.step) idx_q <= idx_q + 1'b1;
			case (state_q)
				ST_IDLE: if (start) begin
					kind_q <= kind;
					if (kind == OP_ADD) state_q <= ST_ADD;
					else if ((kind == OP_TICK && paused) || kind > OP_RESYNC)
						state_q <= ST_DONE;
					else if (kind inside {OP_START, OP_STOP, OP_REMOVE, OP_BIND})
						state_q <= ST_DONE;
					else state_q <= ST_WALK;
				end
				ST_WALK: if (stat.idx_last) state_q <= ST_DONE;
				ST_ADD: if (stat.found || stat.idx_last) state_q <= ST_IDLE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside command");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !busy) else $error("still busy after last");
	a_fire_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.result_kind == RES_FIRED) |-> !result.last)
		else $error("fired marked last");

endmodule

// ----- rtl/ptt_datapath.sv -----
// ptt_datapath: slot state registers and per-slot update unit
// depends on ptt_pkg
`timescale 1ns / 1ps
module ptt_datapath import ptt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     cmd,
	input  ptt_ctl_t ctl,
	output ptt_stat_t stat
);

	localparam int SLOTS = 1 << ID_BITS;

	cmd_t cmd_q;
	logic [ID_BITS-1:0] idx_q;
	logic [SLOTS-1:0] used_q, run_q, rem_q;
	logic [TOTAL_BITS-1:0] runs_q [SLOTS];
	logic [TOTAL_BITS-1:0] total_q [SLOTS];
	logic [TIME_W-1:0] per_q [SLOTS];
	logic [TIME_W-1:0] lt_q [SLOTS];
	logic [OWNER_W-1:0] own_q [SLOTS];

	logic [TIME_W-1:0] elapsed;
	logic [TOTAL_BITS-1:0] runs_nx;
	logic due;
	logic hit;

	assign elapsed = cmd_q.now - lt_q[idx_q];
	assign due = (per_q[idx_q] == '0) || (elapsed >= per_q[idx_q]);
	assign runs_nx = runs_q[idx_q] + 1'b1;
	assign stat.idx_last = (idx_q == ID_BITS'(SLOTS - 1));
	assign stat.found = !used_q[idx_q];
	assign stat.fire = used_q[idx_q] && !rem_q[idx_q] && run_q[idx_q] && due;
	assign hit = used_q[cmd.timer_id];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			run_q <= '0;
			rem_q <= '0;
			idx_q <= '0;
		end else begin
			if (ctl.clr_idx) idx_q <= '0;
			else if (ctl.step) idx_q <= idx_q + 1'b1;
			// single-slot ops applied at accept
			if (ctl.load && hit) begin
				case (cmd.kind)
					OP_START: run_q[cmd.timer_id] <= 1'b1;
					OP_STOP: run_q[cmd.timer_id] <= 1'b0;
					OP_REMOVE: rem_q[cmd.timer_id] <= 1'b1;
					default: ;
				endcase
			end
			// add claims only a free slot, the search steps over used ones
			if (ctl.step && cmd_q.kind == OP_ADD && !used_q[idx_q]) begin
				used_q[idx_q] <= 1'b1;
				run_q[idx_q] <= 1'b1;
				rem_q[idx_q] <= 1'b0;
			end else if (ctl.step && used_q[idx_q]) begin
				case (cmd_q.kind)
					OP_REM_OWNER: if (own_q[idx_q] == cmd_q.owner_tag) rem_q[idx_q] <= 1'b1;
					OP_START_ALL: run_q[idx_q] <= 1'b1;
					OP_STOP_ALL: run_q[idx_q] <= 1'b0;
					OP_REM_ALL: rem_q[idx_q] <= 1'b1;
					OP_TICK: begin
						if (rem_q[idx_q]) begin
							used_q[idx_q] <= 1'b0;
							run_q[idx_q] <= 1'b0;
							rem_q[idx_q] <= 1'b0;
						end else if (stat.fire && total_q[idx_q] != '0
							&& runs_nx == total_q[idx_q]) rem_q[idx_q] <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) cmd_q <= cmd;
		if (ctl.load && hit && cmd.kind == OP_BIND) own_q[cmd.timer_id] <= cmd.owner_tag;
		if (ctl.step && cmd_q.kind == OP_ADD && !used_q[idx_q]) begin
			runs_q[idx_q] <= '0;
			total_q[idx_q] <= cmd_q.repeat_total;
			per_q[idx_q] <= cmd_q.period;
			lt_q[idx_q] <= cmd_q.now;
			own_q[idx_q] <= '0;
		end else if (ctl.step && cmd_q.kind == OP_TICK && stat.fire) begin
			runs_q[idx_q] <= runs_nx;
			lt_q[idx_q] <= lt_q[idx_q] + per_q[idx_q];
		end else if (ctl.step && cmd_q.kind == OP_RESYNC && used_q[idx_q]) begin
			lt_q[idx_q] <= cmd_q.now;
		end
	end

	a_rem_used: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q & ~used_q) == '0) else $error("removed slot not in use");
	a_run_used: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q & ~used_q) == '0) else $error("running slot not in use");
	a_step_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.step && ctl.load)) else $error("step during load");

endmodule

// ----- rtl/periodic_timer_table_top.sv -----
// periodic timer table: 16 slots, one command word per start pulse
// add searches the slots in order for a free one; remove-owner/start-all/stop-all/
// remove-all/resync and unpaused tick walk every slot, then done; others go to done
// busy drops after the last word, next word accepted at the following edge
// fired result per firing slot, done last (add: added/full); results never stall
// reset clears all slots to free; slot payload is written by add before use
`timescale 1ns / 1ps
module periodic_timer_table_top import ptt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic strobe,
	output res_t result
);

	ptt_ctl_t ctl;
	ptt_stat_t stat;

	ptt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(cmd.kind),
		.paused(cmd.paused), .stat(stat), .ctl(ctl), .busy(busy),
		.strobe(strobe), .result(result)
	);

	ptt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl), .stat(stat)
	);

endmodule

// ----- verif/periodic_timer_table_top_test.sv -----
// testbench for periodic_timer_table_top: directed and random command words
// depends on ptt_pkg and the periodic_timer_table_top rtl
`timescale 1ns / 1ps
module periodic_timer_table_top_test;
	import ptt_pkg::*;

	localparam int NSLOT = 16;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic strobe;
	res_t result;

	periodic_timer_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	// predicted table state
	logic [NSLOT-1:0] t_used, t_running, t_removed;
	logic [15:0] t_runs [NSLOT];
	logic [15:0] t_total [NSLOT];
	logic [31:0] t_period [NSLOT];
	logic [31:0] t_last [NSLOT];
	logic [15:0] t_owner [NSLOT];

	res_t pending_results [$];
	int mismatches = 0;
	int words_sent = 0;
	int results_seen = 0;
	int fired_seen = 0;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic res_t mk_res(logic [1:0] k, logic [3:0] id, logic lst);
		res_t r;
		r.result_kind = k;
		r.slot_id = id;
		r.last = lst;
		return r;
	endfunction

	// append one expected result word
	task automatic expect_word(input res_t r);
		pending_results = {pending_results, r};
	endtask

	// apply one command word to the predicted table, queue its results
	task automatic predict_table(input cmd_t c);
		logic hit;
		logic placed;
		int i;
		hit = t_used[c.timer_id];
		case (c.kind)
		OP_ADD: begin
			placed = 1'b0;
			for (i = 0; i < NSLOT; i++) begin
				if (!placed && !t_used[i]) begin
					placed = 1'b1;
					t_used[i] = 1'b1;
					t_running[i] = 1'b1;
					t_removed[i] = 1'b0;
					t_runs[i] = '0;
					t_total[i] = c.repeat_total;
					t_period[i] = c.period;
					t_last[i] = c.now;
					t_owner[i] = '0;
					expect_word(mk_res(RES_ADDED, i[3:0], 1'b1));
				end
			end
			if (!placed)
				expect_word(mk_res(RES_FULL, 4'd0, 1'b1));
		end
		OP_START: if (hit) t_running[c.timer_id] = 1'b1;
		OP_STOP: if (hit) t_running[c.timer_id] = 1'b0;
		OP_REMOVE: if (hit) t_removed[c.timer_id] = 1'b1;
		OP_BIND: if (hit) t_owner[c.timer_id] = c.owner_tag;
		OP_REM_OWNER: for (i = 0; i < NSLOT; i++)
			if (t_used[i] && t_owner[i] == c.owner_tag) t_removed[i] = 1'b1;
		OP_START_ALL: for (i = 0; i < NSLOT; i++) if (t_used[i]) t_running[i] = 1'b1;
		OP_STOP_ALL: for (i = 0; i < NSLOT; i++) if (t_used[i]) t_running[i] = 1'b0;
		OP_REM_ALL: for (i = 0; i < NSLOT; i++) if (t_used[i]) t_removed[i] = 1'b1;
		OP_RESYNC: for (i = 0; i < NSLOT; i++) if (t_used[i]) t_last[i] = c.now;
		OP_TICK: if (!c.paused) begin
			for (i = 0; i < NSLOT; i++) begin
				if (t_used[i]) begin
					if (t_removed[i]) begin
						t_used[i] = 1'b0;
						t_running[i] = 1'b0;
						t_removed[i] = 1'b0;
					end else if (t_running[i] && (t_period[i] == 0 ||
							c.now - t_last[i] >= t_period[i])) begin
						t_runs[i] = t_runs[i] + 16'd1;
						t_last[i] = t_last[i] + t_period[i];
						if (t_total[i] != 0 && t_runs[i] == t_total[i])
							t_removed[i] = 1'b1;
						expect_word(mk_res(RES_FIRED, i[3:0], 1'b0));
					end
				end
			end
		end
		default: ;
		endcase
		if (c.kind != OP_ADD)
			expect_word(mk_res(RES_DONE, 4'd0, 1'b1));
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && strobe) begin
			results_seen++;
			if (result.result_kind == RES_FIRED) fired_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d slot %0d last %0d",
						result.result_kind, result.slot_id, result.last);
			end else begin
				want = pending_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d slot %0d last %0d, got %0d %0d %0d",
							want.result_kind, want.slot_id, want.last,
							result.result_kind, result.slot_id, result.last);
				end
			end
		end
	end

	// send one command word, honoring busy, after a random gap
	// start stays high into the next word when there is no gap
	task automatic send_word(input cmd_t c, input bit gap = 1'b1);
		int wait_n;
		wait_n = gap ? $urandom_range(0, 16) : 0;
		if ($urandom_range(0, 3) == 0) wait_n = 0;
		if (wait_n > 0) begin
			start <= 1'b0;
			repeat (wait_n) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_table(c);
		words_sent++;
	endtask

	function automatic cmd_t rand_fill();
		cmd_t c;
		c.kind = OP_ADD;
		c.timer_id = 4'($urandom_range(0, 15));
		c.owner_tag = 16'($urandom);
		c.period = $urandom;
		c.repeat_total = 16'($urandom);
		c.now = $urandom;
		c.paused = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic cmd_t op_word(logic [3:0] k, logic [3:0] id, logic [15:0] own,
			logic [31:0] per, logic [15:0] tot, logic [31:0] tnow, logic pz);
		cmd_t c;
		c = rand_fill();
		c.kind = k;
		c.timer_id = id;
		c.owner_tag = own;
		c.period = per;
		c.repeat_total = tot;
		c.now = tnow;
		c.paused = pz;
		return c;
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// fill the table past full, edge fields, wrap of time, paused tick
	task automatic test_directed();
		int i;
		for (i = 0; i < 17; i++)
			send_word(op_word(OP_ADD, 0, 0, (i == 0) ? 32'd0 : 32'hFFFF_FFFF,
				(i == 1) ? 16'hFFFF : 16'd2, 32'hFFFF_FFF0, 1'b0));
		send_word(op_word(OP_BIND, 4'd15, 16'hFFFF, 0, 0, 0, 0));
		send_word(op_word(OP_TICK, 0, 0, 0, 0, 32'h0000_0010, 1'b1));
		send_word(op_word(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFEF, 1'b0));
		send_word(op_word(OP_STOP, 4'd0, 0, 0, 0, 0, 0));
		send_word(op_word(OP_TICK, 0, 0, 0, 0, 32'h0000_0000, 1'b0));
		send_word(op_word(OP_START, 4'd0, 0, 0, 0, 0, 0));
		send_word(op_word(OP_REM_OWNER, 0, 16'hFFFF, 0, 0, 0, 0));
		send_word(op_word(4'd15, 0, 0, 0, 0, 0, 0));
		send_word(op_word(OP_RESYNC, 0, 0, 0, 0, 32'h1234_5678, 0));
		send_word(op_word(OP_REM_OWNER, 0, 16'd0, 0, 0, 0, 0));
		send_word(op_word(OP_TICK, 0, 0, 0, 0, 32'h1234_5678, 0));
		send_word(op_word(OP_START_ALL, 0, 0, 0, 0, 0, 0));
		send_word(op_word(OP_STOP_ALL, 0, 0, 0, 0, 0, 0));
		send_word(op_word(OP_REM_ALL, 0, 0, 0, 0, 0, 0));
		send_word(op_word(OP_REMOVE, 4'd3, 0, 0, 0, 0, 0));
		send_word(op_word(OP_TICK, 0, 0, 0, 0, 0, 0));
		// sender holds off until the table has answered everything
		drain();
	endtask

	// mostly adds and ticks on an advancing clock, small periods so slots fire
	task automatic test_random(input int n);
		logic [31:0] clock_now;
		cmd_t c;
		int r;
		int k;
		clock_now = $urandom;
		for (k = 0; k < n; k++) begin
			c = rand_fill();
			r = $urandom_range(0, 99);
			if (r < 25) begin
				c.kind = OP_ADD;
				c.period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8);
				c.repeat_total = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 4));
				c.now = clock_now;
			end else if (r < 60) begin
				c.kind = OP_TICK;
				clock_now = clock_now + $urandom_range(0, 6);
				c.now = clock_now;
				c.paused = ($urandom_range(0, 7) == 0);
			end else if (r < 97) begin
				c.kind = 4'($urandom_range(1, 10));
				if (c.kind == OP_TICK) c.kind = OP_RESYNC;
				c.owner_tag = 16'($urandom_range(0, 3));
				if ($urandom_range(0, 15) == 0) c.owner_tag = 16'($urandom);
				if (c.kind == OP_REM_ALL && $urandom_range(0, 2) != 0) c.kind = OP_STOP;
				c.now = clock_now;
			end else begin
				c.kind = 4'($urandom_range(11, 15));
			end
			send_word(c, k % 50 < 40);
		end
		drain();
	endtask

	initial begin
		t_used = '0;
		t_running = '0;
		t_removed = '0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(360);
		$display("sent %0d command words, checked %0d result words (%0d firings)",
			words_sent, results_seen, fired_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches,
				pending_results.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
